// ===== rtl/baff_pkg.sv =====
// shared types, constants and helper function of the free bitmap allocator
package baff_pkg;

  localparam int IDX_W      = 16;
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;

  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_SUM,
    S_FIND,
    S_FROW,
    S_FWORD,
    S_OUT
  } state_t;

  // position of the lowest zero bit, 0 when none
  function automatic logic [WORD_SHIFT-1:0] lowest_zero64(input logic [WORD_BITS-1:0] w);
    logic [WORD_SHIFT-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        p = WORD_SHIFT'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/baff_if.sv =====
// channel interfaces of the free bitmap allocator: access, result and base register
interface baff_in_if;
  import baff_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [IDX_W-1:0] index;
  logic             value;
  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface baff_out_if;
  import baff_pkg::*;
  logic             valid;
  logic             ready;
  logic             old_bit;
  logic [IDX_W-1:0] first_free;
  logic             none_free;
  logic             index_error;
  modport source (output valid, output old_bit, output first_free, output none_free,
                  output index_error, input ready);
  modport sink   (input valid, input old_bit, input first_free, input none_free,
                  input index_error, output ready);
endinterface

interface baff_cfg_if;
  logic valid;
  logic ready;
  logic index_base;
  modport source (output valid, output index_base, input ready);
  modport sink   (input valid, input index_base, output ready);
endinterface

// ===== rtl/bitmap_allocator_first_free.sv =====
// free bitmap allocator: bit read/write with lowest-free-entry search
//
// Each accepted word runs through the steps below until its result is loaded
// into the output register, and the input is ready again in the cycle after
// that; no new word is taken before then. The steps are: read the addressed
// 64-bit map word, write it back and note whether it became full, update the
// per-word full summary row, pick the lowest non-full summary row from a small
// flop vector, read that row, read the chosen map word and encode its lowest
// zero bit, then load the output register. When the whole map is full the row
// and word reads are skipped. The steps follow the dependent reads of the usage
// ram and the summary ram, one per cycle. A result still waiting in the output
// register holds the block in its last step until that register is taken.
// After reset a clearing pass writes every map word once before the input is
// ready; the base register can be written at any time the block is idle.
module bitmap_allocator_first_free #(
  parameter int MAP_BYTES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  baff_in_if.sink    in_ch,
  baff_out_if.source out_ch,
  baff_cfg_if.sink   cfg_ch
);
  import baff_pkg::*;

  localparam int ENTRY_COUNT = MAP_BYTES * 8;
  localparam int WORD_COUNT  = (ENTRY_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_ROWS    = (WORD_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int ROW_W       = (SUM_ROWS > 1) ? $clog2(SUM_ROWS) : 1;
  localparam int TAIL_BITS   = ENTRY_COUNT % WORD_BITS;
  localparam int ROW_TAIL    = WORD_COUNT % WORD_BITS;
  localparam logic [WORD_BITS-1:0] WORD_PAD =
    (TAIL_BITS == 0) ? '0 : ~((64'd1 << TAIL_BITS) - 64'd1);
  localparam logic [WORD_BITS-1:0] ROW_PAD =
    (ROW_TAIL == 0) ? '0 : ~((64'd1 << ROW_TAIL) - 64'd1);
  localparam logic [IDX_W:0]     ENTRY_LIM = (IDX_W + 1)'(ENTRY_COUNT);
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);
  localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(SUM_ROWS - 1);

  state_t               state_r, state_nxt;
  logic [WADDR_W-1:0]   clr_r, clr_nxt;
  logic [SUM_ROWS-1:0]  top_r, top_nxt;
  logic                 base_r, base_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 op_r, op_nxt;
  logic                 val_r, val_nxt;
  logic                 err_r, err_nxt;
  logic [IDX_W-1:0]     local_r, local_nxt;
  logic                 wfull_r, wfull_nxt;
  logic                 old_r, old_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [WADDR_W-1:0]   fword_r, fword_nxt;
  logic                 none_r, none_nxt;
  logic [IDX_W-1:0]     ff_r, ff_nxt;
  logic                 out_old_r, out_old_nxt;
  logic [IDX_W-1:0]     out_ff_r, out_ff_nxt;
  logic                 out_none_r, out_none_nxt;
  logic                 out_err_r, out_err_nxt;

  logic                 um_we;
  logic [WADDR_W-1:0]   um_waddr, um_raddr;
  logic [WORD_BITS-1:0] um_wdata, um_rdata;
  logic                 sr_we;
  logic [ROW_W-1:0]     sr_waddr, sr_raddr;
  logic [WORD_BITS-1:0] sr_wdata, sr_rdata;

  logic [IDX_W-1:0]     local_in;
  logic                 err_in;
  logic [WADDR_W-1:0]   w_cur;
  logic [9:0]           w_ext;
  logic [ROW_W-1:0]     row_cur;
  logic [WORD_SHIFT-1:0] rbit_cur;
  logic [WORD_SHIFT-1:0] b_cur;
  logic                 do_wr;
  logic [WORD_BITS-1:0] new_word, new_row;
  logic                 top_hit;
  logic [ROW_W-1:0]     top_sel;
  logic [WADDR_W-1:0]   w_found;
  logic [IDX_W:0]       pos;
  logic                 out_load;
  logic                 in_acc;

  baff_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_usage (
    .clk   (clk),
    .we    (um_we),
    .waddr (um_waddr),
    .wdata (um_wdata),
    .raddr (um_raddr),
    .rdata (um_rdata)
  );

  baff_ram #(.WIDTH(WORD_BITS), .DEPTH(SUM_ROWS)) u_summary (
    .clk   (clk),
    .we    (sr_we),
    .waddr (sr_waddr),
    .wdata (sr_wdata),
    .raddr (sr_raddr),
    .rdata (sr_rdata)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.old_bit    = out_old_r;
  assign out_ch.first_free = out_ff_r;
  assign out_ch.none_free  = out_none_r;
  assign out_ch.index_error = out_err_r;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign local_in = in_ch.index - IDX_W'(base_r);
  assign err_in   = (in_ch.index < IDX_W'(base_r)) || ({1'b0, local_in} >= ENTRY_LIM);

  assign w_cur    = local_r[WORD_SHIFT +: WADDR_W];
  assign b_cur    = local_r[WORD_SHIFT-1:0];
  assign w_ext    = 10'(w_cur);
  assign row_cur  = ROW_W'(w_ext >> WORD_SHIFT);
  assign rbit_cur = w_ext[WORD_SHIFT-1:0];
  assign do_wr    = !err_r && (op_r == OP_WRITE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // lowest summary row that still holds a non-full word
  always_comb begin
    top_hit = 1'b0;
    top_sel = '0;
    for (int i = SUM_ROWS - 1; i >= 0; i--) begin
      if (!top_r[i]) begin
        top_hit = 1'b1;
        top_sel = ROW_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    top_nxt    = top_r;
    base_nxt   = base_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    err_nxt    = err_r;
    local_nxt  = local_r;
    wfull_nxt  = wfull_r;
    old_nxt    = old_r;
    row_nxt    = row_r;
    fword_nxt  = fword_r;
    none_nxt   = none_r;
    ff_nxt     = ff_r;
    um_we      = 1'b0;
    um_waddr   = w_cur;
    um_wdata   = '0;
    um_raddr   = w_cur;
    sr_we      = 1'b0;
    sr_waddr   = row_cur;
    sr_wdata   = '0;
    sr_raddr   = row_cur;
    new_word   = um_rdata;
    new_row    = sr_rdata;
    w_found    = '0;
    pos        = '0;

    if (cfg_ch.valid) begin
      base_nxt = cfg_ch.index_base;
    end

    unique case (state_r)
      S_CLR: begin
        um_we    = 1'b1;
        um_waddr = clr_r;
        um_wdata = (clr_r == LAST_WORD) ? WORD_PAD : '0;
        sr_waddr = ROW_W'(clr_r);
        sr_wdata = (ROW_W'(clr_r) == LAST_ROW) ? ROW_PAD : '0;
        sr_we    = (11'(clr_r) < 11'(SUM_ROWS));
        if (clr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + WADDR_W'(1);
        end
      end
      S_IDLE: begin
        um_raddr = local_in[WORD_SHIFT +: WADDR_W];
        if (in_acc) begin
          op_nxt    = in_ch.op;
          val_nxt   = in_ch.value;
          err_nxt   = err_in;
          local_nxt = local_in;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        new_word[b_cur] = val_r;
        old_nxt   = um_rdata[b_cur] && !err_r;
        wfull_nxt = &new_word;
        um_we     = do_wr;
        um_wdata  = new_word;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        new_row[rbit_cur] = wfull_r;
        sr_we    = do_wr;
        sr_wdata = new_row;
        if (do_wr) begin
          top_nxt[row_cur] = &new_row;
        end
        state_nxt = S_FIND;
      end
      S_FIND: begin
        sr_raddr = top_sel;
        row_nxt  = top_sel;
        if (top_hit) begin
          state_nxt = S_FROW;
        end else begin
          none_nxt  = 1'b1;
          ff_nxt    = '0;
          state_nxt = S_OUT;
        end
      end
      S_FROW: begin
        w_found   = WADDR_W'((IDX_W'(row_r) << WORD_SHIFT) | IDX_W'(lowest_zero64(sr_rdata)));
        um_raddr  = w_found;
        fword_nxt = w_found;
        state_nxt = S_FWORD;
      end
      S_FWORD: begin
        pos       = ((IDX_W + 1)'(fword_r) << WORD_SHIFT) |
                    (IDX_W + 1)'(lowest_zero64(um_rdata));
        ff_nxt    = IDX_W'(pos + (IDX_W + 1)'(base_r));
        none_nxt  = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_old_nxt   = out_old_r;
    out_ff_nxt    = out_ff_r;
    out_none_nxt  = out_none_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_old_nxt   = old_r;
      out_ff_nxt    = ff_r;
      out_none_nxt  = none_r;
      out_err_nxt   = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      top_r       <= '0;
      base_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      top_r       <= top_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    err_r      <= err_nxt;
    local_r    <= local_nxt;
    wfull_r    <= wfull_nxt;
    old_r      <= old_nxt;
    row_r      <= row_nxt;
    fword_r    <= fword_nxt;
    none_r     <= none_nxt;
    ff_r       <= ff_nxt;
    out_old_r  <= out_old_nxt;
    out_ff_r   <= out_ff_nxt;
    out_none_r <= out_none_nxt;
    out_err_r  <= out_err_nxt;
  end

  // accepted word always starts with the map word read
  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RD))
    else $error("accepted word did not enter the read step");

  // an out of range index never touches the map
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD || state_r == S_SUM) && err_r) |-> (!um_we && !sr_we))
    else $error("write issued for an out of range index");

  // a full top summary yields a full-map result
  a_full_to_none: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND && (&top_r)) |=> (none_r && ff_r == '0))
    else $error("full map not reported");

  // no word is taken during the clearing pass
  a_clr_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ch.ready)
    else $error("input ready during clearing pass");

endmodule

// ===== rtl/baff_ram.sv =====
// generic simple dual-port ram with registered read
module baff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
